// ===== rtl/core/ubxack_pkg.sv =====
// shared types and constants for the acknowledgement frame matcher
package ubxack_pkg;

    localparam int unsigned FRAME_LEN     = 10;
    localparam int unsigned POS_W         = 4;
    localparam int unsigned ELAPSED_W     = 17;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned CFG_INDEX_W   = 2;

    localparam logic [7:0] SYNC_FIRST      = 8'hB5;
    localparam logic [7:0] SYNC_SECOND     = 8'h62;
    localparam logic [7:0] ACK_CLASS_CODE  = 8'h05;
    localparam logic [7:0] ACK_ID_CODE     = 8'h01;
    localparam logic [7:0] ACK_PAYLOAD_LEN = 8'h02;
    localparam logic [7:0] ACK_LEN_HIGH    = 8'h00;

    localparam logic [7:0]  ACK_CLASS_RESET  = 8'd6;
    localparam logic [7:0]  ACK_ID_RESET     = 8'd36;
    localparam logic [15:0] TIMEOUT_MS_RESET = 16'd5000;

    // sums of the fixed body bytes, used to form the checksum bytes
    localparam logic [7:0] CKA_BASE = 8'd8;
    localparam logic [7:0] CKB_BASE = 8'd43;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_WAITING = 2'd1,
        ST_ACKED   = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ACK_CLASS  = 2'd0,
        REG_ACK_ID     = 2'd1,
        REG_TIMEOUT_MS = 2'd2
    } reg_index_t;

endpackage

// ===== rtl/core/ubx_ack_sequence_matcher_unit.sv =====
// Acknowledgement frame matcher: watches received bytes for a 10-byte ack
// frame for the configured class and id, and counts millisecond ticks against
// timeout_ms. Every transfer in (start, byte or tick) yields exactly one result
// with the status and match count after that item. One item per clock cycle is
// sustained while out_stall is low: an item waits in the input register, then
// the single compare and counter update loads the result register that drives
// result valid. The expected class, id and checksum bytes follow the
// configuration registers as they are at each byte.
module ubx_ack_sequence_matcher_unit
    import ubxack_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             kind,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             status,
    output logic [3:0]             match_count
);

    logic [7:0]  ack_class_reg;
    logic [7:0]  ack_id_reg;
    logic [15:0] timeout_ms_reg;

    logic        in_vld_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;

    logic                 out_vld_reg;
    status_t              out_status_reg;
    logic [POS_W-1:0]     out_count_reg;

    status_t              status_reg;
    status_t              status_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic [ELAPSED_W-1:0] elapsed_inc;

    logic       out_free;
    logic       advance;
    logic       in_take;
    logic [7:0] cka;
    logic [7:0] ckb;
    logic [7:0] expected;
    logic       byte_hit;

    assign out_free = !out_vld_reg || !out_stall;
    assign advance  = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign out_valid   = out_vld_reg;
    assign status      = out_status_reg;
    assign match_count = out_count_reg;

    // fletcher sums over 05 01 02 00 class id reduce to these two adds
    assign cka = CKA_BASE + ack_class_reg + ack_id_reg;
    assign ckb = CKB_BASE + {ack_class_reg[6:0], 1'b0} + ack_id_reg;

    always_comb
    begin
        case (pos_reg)
            4'd0:    expected = SYNC_FIRST;
            4'd1:    expected = SYNC_SECOND;
            4'd2:    expected = ACK_CLASS_CODE;
            4'd3:    expected = ACK_ID_CODE;
            4'd4:    expected = ACK_PAYLOAD_LEN;
            4'd5:    expected = ACK_LEN_HIGH;
            4'd6:    expected = ack_class_reg;
            4'd7:    expected = ack_id_reg;
            4'd8:    expected = cka;
            4'd9:    expected = ckb;
            default: expected = SYNC_FIRST;
        endcase
    end

    assign byte_hit = (pos_reg < POS_W'(FRAME_LEN)) && (byte_reg == expected);
    assign elapsed_inc = (elapsed_reg == {ELAPSED_W{1'b1}}) ?
                         elapsed_reg : elapsed_reg + ELAPSED_W'(1);

    // next state for the item in the input register
    always_comb
    begin
        status_next  = status_reg;
        pos_next     = pos_reg;
        elapsed_next = elapsed_reg;
        case (kind_reg)
            KIND_START:
            begin
                status_next  = ST_WAITING;
                pos_next     = '0;
                elapsed_next = '0;
            end
            KIND_BYTE:
            begin
                if (status_reg == ST_WAITING)
                begin
                    if (byte_hit)
                    begin
                        pos_next = pos_reg + POS_W'(1);
                        if (pos_reg == POS_W'(FRAME_LEN - 1))
                            status_next = ST_ACKED;
                    end
                    else if (byte_reg == SYNC_FIRST)
                        pos_next = POS_W'(1);
                    else
                        pos_next = '0;
                end
            end
            KIND_TICK:
            begin
                if (status_reg == ST_WAITING)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > {1'b0, timeout_ms_reg})
                        status_next = ST_TIMEOUT;
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_class_reg  <= ACK_CLASS_RESET;
            ack_id_reg     <= ACK_ID_RESET;
            timeout_ms_reg <= TIMEOUT_MS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ACK_CLASS:  ack_class_reg  <= cfg_data[7:0];
                REG_ACK_ID:     ack_id_reg     <= cfg_data[7:0];
                REG_TIMEOUT_MS: timeout_ms_reg <= cfg_data;
                default:        ack_class_reg  <= ack_class_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            out_status_reg <= ST_IDLE;
            out_count_reg  <= '0;
            status_reg     <= ST_IDLE;
            pos_reg        <= '0;
            elapsed_reg    <= '0;
        end
        else
        begin
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
            begin
                out_vld_reg    <= 1'b1;
                out_status_reg <= status_next;
                out_count_reg  <= pos_next;
                status_reg     <= status_next;
                pos_reg        <= pos_next;
                elapsed_reg    <= elapsed_next;
            end
            else if (out_free)
                out_vld_reg <= 1'b0;
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= kind;
            byte_reg <= data_byte;
        end
    end

endmodule
